// ===== hdl/pcpa_pkg.sv =====
// Shared types, sizes and codes of the per-CPU page allocator.
// No dependencies; every other file of the block imports this package.
package pcpa_pkg;

    localparam int NUM_CPUS   = 8;
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int HEAD_W = $clog2(NUM_PAGES + 1);
    localparam int OFS_W  = $clog2(PAGE_BYTES);
    localparam int ADDR_W = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_TOP   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [2:0]        cpu;
        logic [ADDR_W-1:0] page_addr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [2:0]        source_cpu;
    } out_item_t;

    typedef struct packed {
        logic              is_free;
        logic              reject;
        logic [CPU_W-1:0]  cpu;
        logic [PAGE_W-1:0] idx;
    } cls_t;

    function automatic logic [CPU_W-1:0] fold_cpu(input logic [2:0] c);
        int r;
        r = 0;
        for (int v = 0; v < 8; v++)
        begin
            if (c == 3'(v))
            begin
                r = v % NUM_CPUS;
            end
        end
        return CPU_W'(r);
    endfunction

    function automatic logic [2:0] to_src(input logic [CPU_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[2:0];
    endfunction

endpackage

// ===== hdl/pcpa_front.sv =====
// Front end: checks free addresses and resolves the requester's list.
// Depends on pcpa_pkg.
module pcpa_front (
    input  pcpa_pkg::in_item_t req,
    input  logic [31:0]        region_start,
    input  logic [31:0]        region_top,
    output pcpa_pkg::cls_t     cls
);
    import pcpa_pkg::*;

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] pg;
    logic              bad;

    always_comb
    begin
        base = region_start & ~ADDR_W'(PAGE_BYTES - 1);
        diff = req.page_addr - base;
        pg   = diff >> OFS_W;
        bad  = (req.page_addr[OFS_W-1:0] != '0) || (req.page_addr < region_start) ||
               (req.page_addr >= region_top) || (pg >= ADDR_W'(NUM_PAGES));
        cls.is_free = (req.cmd == CMD_FREE);
        cls.reject  = (req.cmd == CMD_FREE) && bad;
        cls.cpu     = fold_cpu(req.cpu);
        cls.idx     = pg[PAGE_W-1:0];
    end

endmodule

// ===== hdl/pcpa_queue.sv =====
// Two-entry queue of classified commands between front and back end.
// Depends on pcpa_pkg.
module pcpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcpa_pkg::cls_t push_data,
    input  logic           pop,
    output logic           not_empty,
    output pcpa_pkg::cls_t head_data
);
    import pcpa_pkg::*;

    cls_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_empty = (count_reg != 2'd0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/pcpa_back.sv =====
// Back end: list heads, next-link memory, stealing search and result register.
// Depends on pcpa_pkg.
module pcpa_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  pcpa_pkg::cls_t      cls,
    input  logic [31:0]         region_start,
    output logic                pop,
    output logic                finish,
    output logic                done,
    output pcpa_pkg::out_item_t rsp
);
    import pcpa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [HEAD_W-1:0] head_reg [NUM_CPUS];
    logic [HEAD_W-1:0] link_mem [NUM_PAGES];
    logic [HEAD_W-1:0] rd_data_reg;
    logic [PAGE_W-1:0] pg_reg;
    logic [CPU_W-1:0]  src_reg;
    logic              done_reg;
    out_item_t         rsp_reg;
    out_item_t         rsp_next;

    logic [ADDR_W-1:0] base;
    logic [CPU_W-1:0]  first;
    logic              any_ne;
    logic [CPU_W-1:0]  sel;
    logic [HEAD_W-1:0] sel_head;
    logic [HEAD_W-1:0] top_m1;
    logic              do_push;
    logic              do_read;

    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        base   = region_start & ~ADDR_W'(PAGE_BYTES - 1);
        first  = '0;
        any_ne = 1'b0;
        for (int j = NUM_CPUS - 1; j >= 0; j--)
        begin
            if (head_reg[j] != '0)
            begin
                first  = CPU_W'(j);
                any_ne = 1'b1;
            end
        end
        if (cls.is_free || (head_reg[cls.cpu] != '0))
        begin
            sel = cls.cpu;
        end
        else
        begin
            sel = first;
        end
        sel_head = head_reg[sel];
        top_m1   = sel_head - HEAD_W'(1);

        pop        = 1'b0;
        finish     = 1'b0;
        do_push    = 1'b0;
        do_read    = 1'b0;
        state_next = state_reg;
        rsp_next   = '{status: ST_OK, alloc_addr: '0, source_cpu: 3'd0};

        case (state_reg)
            S_IDLE:
            begin
                if (not_empty)
                begin
                    pop = 1'b1;
                    if (cls.is_free)
                    begin
                        finish = 1'b1;
                        if (cls.reject)
                        begin
                            rsp_next.status = ST_REJECT;
                        end
                        else
                        begin
                            do_push = 1'b1;
                        end
                    end
                    else if (!any_ne)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        do_read    = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                finish              = 1'b1;
                rsp_next.alloc_addr = base + (ADDR_W'(pg_reg) << OFS_W);
                rsp_next.source_cpu = to_src(src_reg);
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (do_push)
            begin
                head_reg[cls.cpu] <= HEAD_W'(cls.idx) + HEAD_W'(1);
            end
            else if (state_reg == S_READ)
            begin
                head_reg[src_reg] <= rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            link_mem[cls.idx] <= sel_head;
        end
        if (do_read)
        begin
            rd_data_reg <= link_mem[top_m1[PAGE_W-1:0]];
            pg_reg      <= top_m1[PAGE_W-1:0];
            src_reg     <= sel;
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== hdl/per_cpu_page_allocator.sv =====
// Path: a free, rejected free or allocate with nothing free passes the queue entry, then the
// result register; an allocate that succeeds also passes S_READ (link read, then head update).
// One command at a time: busy stays high until the result is issued.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset: asynchronous, active low; all free lists empty, region registers zero.
module per_cpu_page_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pcpa_pkg::in_item_t  req,
    output logic                done,
    output pcpa_pkg::out_item_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import pcpa_pkg::*;

    logic [31:0] region_start_reg;
    logic [31:0] region_top_reg;
    logic        busy_reg;
    logic        busy_next;
    logic        accept;
    logic        pop;
    logic        finish;
    logic        not_empty;
    cls_t        cls_in;
    cls_t        cls_out;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            region_start_reg <= '0;
            region_top_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REGION_START: region_start_reg <= cfg_data;
                    CFG_REGION_TOP:   region_top_reg   <= cfg_data;
                    default:          region_top_reg   <= region_top_reg;
                endcase
            end
        end
    end

    pcpa_front u_front (
        .req          (req),
        .region_start (region_start_reg),
        .region_top   (region_top_reg),
        .cls          (cls_in)
    );

    pcpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (cls_in),
        .pop       (pop),
        .not_empty (not_empty),
        .head_data (cls_out)
    );

    pcpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .cls          (cls_out),
        .region_start (region_start_reg),
        .pop          (pop),
        .finish       (finish),
        .done         (done),
        .rsp          (rsp)
    );

endmodule

// ===== hdl/pcpa_checker.sv =====
// Port-level checks of the per-CPU page allocator, bound to the top level.
// Depends on pcpa_pkg and per_cpu_page_allocator.
module pcpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input pcpa_pkg::out_item_t rsp
);
    import pcpa_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results for one command");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_EMPTY ||
                  rsp.status == ST_REJECT))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.alloc_addr == '0 && rsp.source_cpu == 3'd0)
        else $error("failed command carries an address or source");

endmodule

bind per_cpu_page_allocator pcpa_checker u_pcpa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
